>>> design/prle_pkg.sv
// Shared types and constants for the planar run-length row decoder.
// Used by every module of the block; depends on nothing else.

package prle_pkg;

  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [3:0]  MAX_PLANES = 4'd9;
  localparam logic [3:0]  MAX_COLOUR_PLANES = 4'd8;
  localparam logic [12:0] ROUND_MASK = 13'd15;
  localparam logic [7:0]  NOP_HEADER = 8'h80;
  localparam logic [8:0]  RUN_BASE   = 9'd257;

  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_COMPRESSED   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_PLANE_COUNT  = 3'd3,
    REG_HAS_MASK     = 3'd4
  } prle_reg_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_RUN     = 4'b0100,
    PH_SKIP    = 4'b1000
  } prle_phase_t;

  typedef struct packed {
    logic        compressed;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [3:0]  plane_count;
    logic        has_mask;
  } prle_cfg_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  repeat_res;
    logic [3:0]  plane;
    logic [11:0] row;
    logic [8:0]  column;
    logic        last_of_image;
    logic        overrun;
  } prle_result_t;

endpackage

>>> design/prle_cfg_regs.sv
// Configuration register file on the APB-style port.
// Depends on prle_pkg for the register map and the configuration struct.

module prle_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prle_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output prle_pkg::prle_cfg_t         cfg
);
  import prle_pkg::*;

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.compressed   <= 1'b1;
      cfg.image_width  <= 13'd320;
      cfg.image_height <= 13'd200;
      cfg.plane_count  <= 4'd5;
      cfg.has_mask     <= 1'b0;
    end else if (wr_en) begin
      unique case (index)
        REG_COMPRESSED:   cfg.compressed   <= pwdata[0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[12:0];
        REG_PLANE_COUNT:  cfg.plane_count  <= pwdata[3:0];
        REG_HAS_MASK:     cfg.has_mask     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_COMPRESSED:   prdata = {31'd0, cfg.compressed};
      REG_IMAGE_WIDTH:  prdata = {19'd0, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, cfg.image_height};
      REG_PLANE_COUNT:  prdata = {28'd0, cfg.plane_count};
      REG_HAS_MASK:     prdata = {31'd0, cfg.has_mask};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> design/prle_decoder.sv
// Decode state and the combinational step for one body byte.
// Depends on prle_pkg; fed by the register file, drains into prle_out_skid.

module prle_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  prle_pkg::prle_cfg_t    cfg,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   start_of_image,
  output logic                   res_valid,
  output prle_pkg::prle_result_t res
);
  import prle_pkg::*;

  prle_phase_t phase, phase_next, ph_e;
  logic [6:0]  literal_left, lit_next, lit_e;
  logic [7:0]  run_length, run_next, run_e;
  logic [8:0]  column_pos, col_next, col_e, col_c;
  logic [3:0]  plane_pos, pl_next, pl_e, pl_c;
  logic [11:0] row_pos, row_next, row_e, row_c;
  logic        image_done, done_next, done_e;

  logic [12:0] w_clamp, w_round, h_clamp;
  logic [3:0]  pc_clamp, pt_sum, pt;
  logic [9:0]  bpr, bpr_m1;
  logic [12:0] rt, rt_m1;

  logic [7:0]  emit_count, cnt;
  logic [9:0]  left, col_sum;
  logic        clip, row_end, plane_wrap, image_end;
  logic [4:0]  pl_inc;
  logic [12:0] row_inc;
  logic [8:0]  e_col;
  logic [3:0]  e_pl;
  logic [11:0] e_row;
  logic        e_last;
  logic        emit_take, force_overrun;

  always_comb begin
    if (cfg.image_width == 13'd0) begin
      w_clamp = 13'd1;
    end else if (cfg.image_width > MAX_WIDTH) begin
      w_clamp = MAX_WIDTH;
    end else begin
      w_clamp = cfg.image_width;
    end
    w_round = w_clamp + ROUND_MASK;
    bpr     = {w_round[12:4], 1'b0};
    bpr_m1  = bpr - 10'd1;

    if (cfg.image_height == 13'd0) begin
      h_clamp = 13'd1;
    end else if (cfg.image_height > MAX_HEIGHT) begin
      h_clamp = MAX_HEIGHT;
    end else begin
      h_clamp = cfg.image_height;
    end
    rt    = h_clamp;
    rt_m1 = rt - 13'd1;

    if (cfg.plane_count == 4'd0) begin
      pc_clamp = 4'd1;
    end else if (cfg.plane_count > MAX_COLOUR_PLANES) begin
      pc_clamp = MAX_COLOUR_PLANES;
    end else begin
      pc_clamp = cfg.plane_count;
    end
    pt_sum = pc_clamp + {3'd0, cfg.has_mask};
    pt     = (pt_sum > MAX_PLANES) ? MAX_PLANES : pt_sum;
  end

  always_comb begin
    if (start_of_image) begin
      ph_e   = PH_HEADER;
      lit_e  = '0;
      run_e  = '0;
      col_e  = '0;
      pl_e   = '0;
      row_e  = '0;
      done_e = 1'b0;
    end else begin
      ph_e   = phase;
      lit_e  = literal_left;
      run_e  = run_length;
      col_e  = column_pos;
      pl_e   = plane_pos;
      row_e  = row_pos;
      done_e = image_done;
    end
    col_c = ({1'b0, col_e} >= bpr) ? bpr_m1[8:0] : col_e;
    pl_c  = (pl_e >= pt) ? (pt - 4'd1) : pl_e;
    row_c = ({1'b0, row_e} >= rt) ? rt_m1[11:0] : row_e;
  end

  always_comb begin
    emit_count = (cfg.compressed && ph_e == PH_RUN) ? run_e : 8'd1;
    left       = bpr - {1'b0, col_c};
    clip       = {2'b00, emit_count} > left;
    cnt        = clip ? left[7:0] : emit_count;
    col_sum    = {1'b0, col_c} + {2'b00, cnt};
    row_end    = col_sum >= bpr;
    pl_inc     = {1'b0, pl_c} + 5'd1;
    plane_wrap = pl_inc >= {1'b0, pt};
    row_inc    = {1'b0, row_c} + 13'd1;
    image_end  = row_inc >= rt;
    e_col      = row_end ? 9'd0 : col_sum[8:0];
    e_pl       = row_end ? (plane_wrap ? 4'd0 : pl_inc[3:0]) : pl_c;
    e_row      = (row_end && plane_wrap) ? (image_end ? 12'd0 : row_inc[11:0]) : row_c;
    e_last     = row_end && plane_wrap && image_end;
  end

  always_comb begin
    phase_next    = phase;
    lit_next      = literal_left;
    run_next      = run_length;
    col_next      = column_pos;
    pl_next       = plane_pos;
    row_next      = row_pos;
    done_next     = image_done;
    emit_take     = 1'b0;
    force_overrun = 1'b0;
    if (accept) begin
      phase_next = ph_e;
      lit_next   = lit_e;
      run_next   = run_e;
      col_next   = col_e;
      pl_next    = pl_e;
      row_next   = row_e;
      done_next  = done_e;
      if (!done_e) begin
        col_next = col_c;
        pl_next  = pl_c;
        row_next = row_c;
        if (!cfg.compressed) begin
          phase_next = PH_HEADER;
          lit_next   = '0;
          emit_take  = 1'b1;
        end else begin
          unique case (ph_e)
            PH_HEADER: begin
              if (data_byte < NOP_HEADER) begin
                lit_next   = data_byte[6:0];
                phase_next = PH_LITERAL;
              end else if (data_byte != NOP_HEADER) begin
                run_next   = 8'(RUN_BASE - {1'b0, data_byte});
                phase_next = PH_RUN;
              end
            end
            PH_LITERAL: begin
              emit_take = 1'b1;
              if (lit_e != 7'd0) begin
                lit_next = lit_e - 7'd1;
              end else begin
                phase_next = PH_HEADER;
              end
              if (row_end && lit_e != 7'd0) begin
                force_overrun = 1'b1;
                phase_next    = PH_SKIP;
              end
            end
            PH_RUN: begin
              emit_take  = 1'b1;
              phase_next = PH_HEADER;
            end
            PH_SKIP: begin
              if (lit_e == 7'd0) begin
                phase_next = PH_HEADER;
              end else begin
                lit_next = lit_e - 7'd1;
              end
            end
            default: phase_next = PH_HEADER;
          endcase
        end
        if (emit_take) begin
          col_next  = e_col;
          pl_next   = e_pl;
          row_next  = e_row;
          done_next = e_last;
        end
      end
    end
  end

  assign res_valid         = emit_take;
  assign res.value         = data_byte;
  assign res.repeat_res    = cnt;
  assign res.plane         = pl_c;
  assign res.row           = row_c;
  assign res.column        = col_c;
  assign res.last_of_image = e_last;
  assign res.overrun       = clip || force_overrun;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      literal_left <= '0;
      run_length   <= '0;
      column_pos   <= '0;
      plane_pos    <= '0;
      row_pos      <= '0;
      image_done   <= 1'b0;
    end else begin
      phase        <= phase_next;
      literal_left <= lit_next;
      run_length   <= run_next;
      column_pos   <= col_next;
      plane_pos    <= pl_next;
      row_pos      <= row_next;
      image_done   <= done_next;
    end
  end

  a_repeat_fits_row: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.repeat_res != 8'd0) &&
                  (({1'b0, res.column} + {2'b00, res.repeat_res}) <= bpr))
    else $error("result runs past the end of the plane row");

  a_last_sets_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_of_image |=> image_done)
    else $error("final write did not close the image");

  a_quiet_after_image: assert property (@(posedge clk) disable iff (rst)
    accept && image_done && !start_of_image |-> !res_valid)
    else $error("result produced after the end of the image");

endmodule

>>> design/prle_out_skid.sv
// Output register with a one-entry skid stage on the result channel.
// Depends on prle_pkg for the result struct; fed by prle_decoder.

module prle_out_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  prle_pkg::prle_result_t res,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output prle_pkg::prle_result_t out_res
);
  import prle_pkg::*;

  logic         skid_valid;
  prle_result_t skid_res;
  logic         take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the output register is empty");

  a_no_request_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !res_valid)
    else $error("request arrived while both entries were occupied");

  a_stalled_request_parked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && res_valid |=> skid_valid)
    else $error("request lost while the output was stalled");

endmodule

>>> design/planar_rle_row_decoder.sv
// Top level of the planar run-length row decoder.
// Instantiates prle_cfg_regs, prle_decoder and prle_out_skid; uses prle_pkg.
//
//   Channel   Handshake                 Payload
//   config    psel/penable/pwrite       paddr, pwdata, prdata (pready held high)
//   data      data_valid/data_stall     data_byte, start_of_image
//   result    result_valid/result_stall value, repeat_res, plane, row, column,
//                                       last_of_image, overrun
//
// One body byte is accepted per cycle while data_stall is low; its result is registered
// at the accepting edge. The decode step is one pass through the state logic between the
// accepted byte and the output register.
// Reset is synchronous and restores the register defaults and row 0, plane 0, column 0.
// data_stall rises only when the output register and its skid entry are both occupied.

module planar_rle_row_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prle_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        start_of_image,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [7:0]                  value,
  output logic [7:0]                  repeat_res,
  output logic [3:0]                  plane,
  output logic [11:0]                 row,
  output logic [8:0]                  column,
  output logic                        last_of_image,
  output logic                        overrun
);
  import prle_pkg::*;

  prle_cfg_t    cfg;
  logic         accept;
  logic         res_valid;
  prle_result_t res;
  prle_result_t out_res;
  logic         full;

  assign data_stall = full;
  assign accept     = data_valid && !full;

  prle_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prle_decoder u_dec (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .res_valid      (res_valid),
    .res            (res)
  );

  prle_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_res   (out_res)
  );

  assign value         = out_res.value;
  assign repeat_res    = out_res.repeat_res;
  assign plane         = out_res.plane;
  assign row           = out_res.row;
  assign column        = out_res.column;
  assign last_of_image = out_res.last_of_image;
  assign overrun       = out_res.overrun;

endmodule

>>> verif/planar_rle_row_decoder_tb.sv
// Self-checking testbench for planar_rle_row_decoder: APB register set-up, PackBits
// body streams with random valid/stall idling, and a scoreboard that predicts each write.
// Depends on prle_pkg and the planar_rle_row_decoder RTL only.
`timescale 1ns / 100ps

module planar_rle_row_decoder_tb;
  import prle_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned PHASE_BUDGET  = 160;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned DRAIN_LIMIT   = 10000;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SPARE_REG     = 5;

  class plane_write_checker;
    logic         compressed;
    logic [12:0]  image_width;
    logic [12:0]  image_height;
    logic [3:0]   plane_count;
    logic         has_mask;
    prle_phase_t  step_phase;
    logic [6:0]   literal_left;
    logic [7:0]   run_length;
    logic [8:0]   column_pos;
    logic [3:0]   plane_pos;
    logic [11:0]  row_pos;
    bit           image_done;
    prle_result_t pending_writes[$];
    int unsigned  live_bytes;
    int unsigned  checked;
    int unsigned  clipped;
    int unsigned  images;
    int unsigned  errors;

    function new();
      compressed   = 1'b1;
      image_width  = 13'd320;
      image_height = 13'd200;
      plane_count  = 4'd5;
      has_mask     = 1'b0;
      restart();
    endfunction

    function void restart();
      step_phase   = PH_HEADER;
      literal_left = '0;
      run_length   = '0;
      column_pos   = '0;
      plane_pos    = '0;
      row_pos      = '0;
      image_done   = 1'b0;
    endfunction

    function void note_register(input int unsigned idx, input logic [31:0] v);
      case (idx)
        REG_COMPRESSED:   compressed   = v[0];
        REG_IMAGE_WIDTH:  image_width  = v[12:0];
        REG_IMAGE_HEIGHT: image_height = v[12:0];
        REG_PLANE_COUNT:  plane_count  = v[3:0];
        REG_HAS_MASK:     has_mask     = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned row_bytes();
      int unsigned w;
      w = 32'(image_width);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = 32'(MAX_WIDTH);
      return ((w + 32'(ROUND_MASK)) >> 4) << 1;
    endfunction

    function int unsigned rows_total();
      int unsigned h;
      h = 32'(image_height);
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = 32'(MAX_HEIGHT);
      return h;
    endfunction

    function int unsigned planes_total();
      int unsigned p;
      p = 32'(plane_count);
      if (p < 1) p = 1;
      if (p > MAX_COLOUR_PLANES) p = 32'(MAX_COLOUR_PLANES);
      p += 32'(has_mask);
      if (p > MAX_PLANES) p = 32'(MAX_PLANES);
      return p;
    endfunction

    function prle_result_t plane_write(input logic [7:0] val, input int unsigned count,
                                       output bit row_done);
      prle_result_t w;
      int unsigned bpr, col, pl, rw;
      bpr = row_bytes();
      w.overrun = 1'b0;
      w.last_of_image = 1'b0;
      if (count > bpr - column_pos) begin
        count = bpr - column_pos;
        w.overrun = 1'b1;
      end
      w.value      = val;
      w.repeat_res = count[7:0];
      w.plane      = plane_pos;
      w.row        = row_pos;
      w.column     = column_pos;
      col = column_pos + count;
      row_done = (col >= bpr);
      if (row_done) begin
        col = 0;
        pl = plane_pos + 1;
        if (pl >= planes_total()) begin
          pl = 0;
          rw = row_pos + 1;
          if (rw >= rows_total()) begin
            rw = 0;
            image_done = 1'b1;
            w.last_of_image = 1'b1;
          end
          row_pos = 12'(rw);
        end
        plane_pos = 4'(pl);
      end
      column_pos = 9'(col);
      return w;
    endfunction

    // Advances the decode state by one request and queues the write it causes, if any.
    function void decode_byte(input logic [7:0] b, input logic soi);
      prle_result_t w;
      int unsigned bpr, pt, rt;
      bit row_done, more;
      if (soi) restart();
      if (image_done) return;
      live_bytes++;
      bpr = row_bytes();
      pt = planes_total();
      rt = rows_total();
      if (column_pos >= bpr) column_pos = 9'(bpr - 1);
      if (plane_pos >= pt) plane_pos = 4'(pt - 1);
      if (row_pos >= rt) row_pos = 12'(rt - 1);
      if (!compressed) begin
        step_phase = PH_HEADER;
        literal_left = '0;
        w = plane_write(b, 1, row_done);
        pending_writes.push_back(w);
        return;
      end
      case (step_phase)
        PH_HEADER: begin
          if (b < NOP_HEADER) begin
            literal_left = b[6:0];
            step_phase = PH_LITERAL;
          end else if (b > NOP_HEADER) begin
            run_length = 8'(RUN_BASE - {1'b0, b});
            step_phase = PH_RUN;
          end
        end
        PH_LITERAL: begin
          more = (literal_left != 0);
          if (more) literal_left--;
          else step_phase = PH_HEADER;
          w = plane_write(b, 1, row_done);
          if (row_done && more) begin
            w.overrun = 1'b1;
            step_phase = PH_SKIP;
          end
          pending_writes.push_back(w);
        end
        PH_RUN: begin
          step_phase = PH_HEADER;
          w = plane_write(b, 32'(run_length), row_done);
          pending_writes.push_back(w);
        end
        default: begin
          if (literal_left == 0) step_phase = PH_HEADER;
          else literal_left--;
        end
      endcase
    endfunction

    function void compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_write(input prle_result_t got);
      prle_result_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual value %0d plane %0d row %0d",
                 $time, got.value, got.plane, got.row);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      checked++;
      if (want.overrun) clipped++;
      if (want.last_of_image) images++;
      compare_field("value", want.value, got.value);
      compare_field("repeat_res", want.repeat_res, got.repeat_res);
      compare_field("plane", want.plane, got.plane);
      compare_field("row", want.row, got.row);
      compare_field("column", want.column, got.column);
      compare_field("last_of_image", want.last_of_image, got.last_of_image);
      compare_field("overrun", want.overrun, got.overrun);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                data_valid = 1'b0;
  logic                data_stall;
  logic [7:0]          data_byte = '0;
  logic                start_of_image = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [7:0]          value;
  logic [7:0]          repeat_res;
  logic [3:0]          plane;
  logic [11:0]         row;
  logic [8:0]          column;
  logic                last_of_image;
  logic                overrun;

  plane_write_checker  sb = new();
  bit                  calm = 1'b0;
  bit                  hold_results = 1'b0;
  bit                  restart_next = 1'b0;
  int unsigned         phase_bytes = 0;
  int unsigned         cycle_count = 0;

  planar_rle_row_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .value          (value),
    .repeat_res     (repeat_res),
    .plane          (plane),
    .row            (row),
    .column         (column),
    .last_of_image  (last_of_image),
    .overrun        (overrun)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d writes outstanding", $time,
               sb.pending_writes.size());
      $display("planar_rle_row_decoder test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    prle_result_t seen;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        seen.value         = value;
        seen.repeat_res    = repeat_res;
        seen.plane         = plane;
        seen.row           = row;
        seen.column        = column;
        seen.last_of_image = last_of_image;
        seen.overrun       = overrun;
        sb.check_write(seen);
      end
      if (data_valid && !data_stall) sb.decode_byte(data_byte, start_of_image);
    end
  end

  initial begin : result_side
    int unsigned len;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
        hold_results = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        result_stall <= 1'b1;
        repeat (len) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    data_valid     <= 1'b1;
    data_byte      <= b;
    start_of_image <= restart_next;
    restart_next = 1'b0;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    phase_bytes++;
    gap = sender_gap();
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    data_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] v);
    logic [31:0] byte_addr;
    byte_addr = idx << 2;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= byte_addr[ADDR_W-1:0];
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.note_register(idx, v);
  endtask

  task automatic write_all(input logic c, input int unsigned w, input int unsigned h,
                           input int unsigned p, input logic m);
    write_reg(REG_COMPRESSED, 32'(c));
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PLANE_COUNT, p);
    write_reg(REG_HAS_MASK, 32'(m));
  endtask

  task automatic pick_settings(input int unsigned phase_no);
    int unsigned r;
    case (phase_no)
      0: begin
        write_reg(SPARE_REG, $urandom());
        write_all(1'b1, 0, 0, 0, 1'b0);
      end
      1: write_all(1'b1, 8191, 1, 15, 1'b1);
      2: write_all(1'b0, 4096, 8191, 8, 1'b0);
      3: write_all(1'b0, 1, 1, 1, 1'b1);
      4: write_all(1'b1, 4096, 4096, 8, 1'b1);
      5: write_all(1'b1, 16, 1, 1, 1'b0);
      default: begin
        if ($urandom_range(0, 4) < 2)
          write_reg(REG_COMPRESSED, 32'($urandom_range(0, 3) != 0));
        if ($urandom_range(0, 4) < 3) begin
          r = $urandom_range(0, 19);
          write_reg(REG_IMAGE_WIDTH, r < 17 ? $urandom_range(1, 64) :
                                     r < 19 ? $urandom_range(65, 4096) :
                                              $urandom_range(0, 8191));
        end
        if ($urandom_range(0, 4) < 3) begin
          r = $urandom_range(0, 19);
          write_reg(REG_IMAGE_HEIGHT, r < 18 ? $urandom_range(1, 3) : $urandom_range(0, 8191));
        end
        if ($urandom_range(0, 4) < 3) begin
          r = $urandom_range(0, 19);
          write_reg(REG_PLANE_COUNT, r < 15 ? $urandom_range(1, 4) : $urandom_range(0, 15));
        end
        if ($urandom_range(0, 4) < 2) write_reg(REG_HAS_MASK, $urandom_range(0, 1));
      end
    endcase
  endtask

  // One plane row: raw bytes, or packets with the odd no-op header and over-long packet.
  task automatic send_plane_row(input int unsigned bpr);
    int unsigned left, len, r, cap;
    left = bpr;
    while (left > 0 && phase_bytes < PHASE_BUDGET) begin
      if (!sb.compressed) begin
        send_byte(8'($urandom_range(0, 255)));
        left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_byte(NOP_HEADER);
        end else if (r < 12) begin
          if ($urandom_range(0, 1) == 1) begin
            len = $urandom_range(2, 128);
            send_byte(8'(RUN_BASE - len));
            send_byte(8'($urandom_range(0, 255)));
          end else begin
            len = $urandom_range(1, 128);
            send_byte(8'(len - 1));
            repeat (len) send_byte(8'($urandom_range(0, 255)));
          end
          left = (len >= left) ? 0 : left - len;
        end else if (left >= 2 && (r < 55 || bpr > 64)) begin
          cap = (left < 128) ? left : 128;
          len = $urandom_range(2, cap);
          send_byte(8'(RUN_BASE - len));
          send_byte(8'($urandom_range(0, 255)));
          left -= len;
        end else begin
          cap = (left < 32) ? left : 32;
          len = $urandom_range(1, cap);
          send_byte(8'(len - 1));
          repeat (len) send_byte(8'($urandom_range(0, 255)));
          left -= len;
        end
      end
    end
  endtask

  task automatic run_phase(input int unsigned phase_no);
    int unsigned bpr, plane_rows;
    settle_idle();
    pick_settings(phase_no);
    calm = (phase_no % 5 == 4) || (phase_no == 2);
    if (phase_no == 2) hold_results = 1'b1;
    restart_next = (phase_no != 5) && (phase_no < 6 || $urandom_range(0, 9) != 0);
    phase_bytes = 0;
    if (phase_no >= 6 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    bpr = sb.row_bytes();
    plane_rows = sb.rows_total() * sb.planes_total();
    while (plane_rows > 0 && phase_bytes < PHASE_BUDGET) begin
      if (phase_no >= 6 && $urandom_range(0, 49) == 0) restart_next = 1'b1;
      send_plane_row(bpr);
      plane_rows--;
    end
    if (plane_rows == 0 && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    logic [7:0]  packed_bytes[$];
    logic [7:0]  raw_bytes[$];
    int unsigned opening_live;
    int unsigned phase_no;
    int unsigned waited;
    packed_bytes = '{8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h81, 8'hA5, 8'hDB, 8'h5A,
                     8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                     8'h01, 8'h80, 8'h7F, 8'h03};
    raw_bytes = '{8'h80, 8'hFF, 8'h00};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    restart_next = 1'b1;
    foreach (packed_bytes[i]) send_byte(packed_bytes[i]);
    settle_idle();
    write_reg(REG_COMPRESSED, 32'd0);
    foreach (raw_bytes[i]) send_byte(raw_bytes[i]);
    settle_idle();
    opening_live = sb.live_bytes;

    phase_no = 0;
    while (sb.live_bytes < opening_live + RANDOM_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end

    data_valid <= 1'b0;
    calm = 1'b1;
    waited = 0;
    while (sb.pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_writes.size() != 0) begin
      $display("%0t: %0d expected writes never arrived, expected 0 outstanding", $time,
               sb.pending_writes.size());
      sb.errors++;
    end

    $display("Decoded %0d body bytes across %0d register settings, raw and packed rows,",
             sb.live_bytes, phase_no + 2);
    $display("checking %0d writes: %0d clipped at a row end, %0d image ends; %0d errors.",
             sb.checked, sb.clipped, sb.images, sb.errors);
    if (sb.errors == 0) begin
      $display("planar_rle_row_decoder test passed");
    end else begin
      $display("planar_rle_row_decoder test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/prle_pkg.sv
design/prle_cfg_regs.sv
design/prle_decoder.sv
design/prle_out_skid.sv
design/planar_rle_row_decoder.sv
verif/planar_rle_row_decoder_tb.sv
